FILE: rtl/source_byte_tokenizer_top_assert.svh
// ----------------------------------------------------------------------------
// source_byte_tokenizer_top_assert.svh
// Assertion macros for the tokenizer; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SOURCE_BYTE_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_BYTE_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTH
`define SBT_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
`define SBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBT_ASSERT(lbl, expr)
`define SBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// Types, constants and character-class functions of the source tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int POS_W      = 16;
    localparam int KW_CHARS   = 6;
    localparam int PREFIX_W   = 8 * KW_CHARS;
    localparam int LEN_W      = 16;
    localparam int KIND_W     = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;
    localparam int KW_COUNT   = 14;
    localparam int OP_COUNT   = 7;
    localparam int SINGLE_COUNT = 13;

    localparam logic [KIND_W-1:0] K_EOF   = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT = 6'd1;
    localparam logic [KIND_W-1:0] K_INT   = 6'd2;
    localparam logic [KIND_W-1:0] K_KW0   = 6'd3;
    localparam logic [KIND_W-1:0] K_SLASH = 6'd31;
    localparam logic [KIND_W-1:0] K_BAD   = 6'd47;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    typedef enum logic [3:0] {
        M_IDLE,
        M_WORD,
        M_NUMBER,
        M_OPER,
        M_SLASH,
        M_LINE,
        M_BLOCK,
        M_BLOCK_STAR,
        M_HALT
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [15:0]       line;
        logic [15:0]       column;
        logic [15:0]       length;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_emit;

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_entry;

    typedef struct packed {
        logic                 hit;
        logic [2:0]           idx;
    } t_op_hit;

    // keyword text, first character in the low byte
    localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
        PREFIX_W'("nf"),    PREFIX_W'("tel"),   PREFIX_W'("tum"),
        PREFIX_W'("fi"),    PREFIX_W'("esle"),  PREFIX_W'("nruter"),
        PREFIX_W'("23i"),   PREFIX_W'("eurt"),  PREFIX_W'("eslaf"),
        PREFIX_W'("elihw"), PREFIX_W'("rof"),   PREFIX_W'("pool"),
        PREFIX_W'("hctam"), PREFIX_W'("efasnu")
    };

    localparam logic [7:0] OP_LEAD [OP_COUNT] = '{"-", "!", "=", "<", ">", "&", "|"};
    localparam logic [KIND_W-1:0] OP_SINGLE [OP_COUNT] = '{
        6'd29, 6'd33, 6'd27, 6'd34, 6'd36, 6'd40, 6'd42};
    localparam logic [7:0] OP_NEXT1 [OP_COUNT] = '{">", "=", "=", "=", "=", "&", "|"};
    localparam logic [KIND_W-1:0] OP_KIND1 [OP_COUNT] = '{
        6'd26, 6'd39, 6'd38, 6'd35, 6'd37, 6'd41, 6'd43};
    localparam logic [7:0] OP_NEXT2 [OP_COUNT] = '{
        8'h00, 8'h00, 8'h00, "<", ">", 8'h00, 8'h00};
    localparam logic [KIND_W-1:0] OP_KIND2 [OP_COUNT] = '{
        6'd0, 6'd0, 6'd0, 6'd45, 6'd46, 6'd0, 6'd0};

    localparam logic [7:0] SINGLE_CHAR [SINGLE_COUNT] = '{
        "(", ")", "{", "}", "[", "]", ",", ";", ":", "+", "*", "%", "^"};
    localparam logic [KIND_W-1:0] SINGLE_KIND [SINGLE_COUNT] = '{
        6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd28, 6'd30, 6'd32, 6'd44};

    function automatic logic is_letter(input logic [7:0] b);
        return (b inside {["a":"z"], ["A":"Z"], "_"});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b inside {["0":"9"]});
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b inside {8'h20, [8'h09:8'h0D]});
    endfunction

    function automatic logic [KIND_W-1:0] word_kind(input logic [PREFIX_W-1:0] prefix,
                                                    input logic [LEN_W-1:0] run_len);
        logic [KIND_W-1:0] kind;
        kind = K_IDENT;
        if (run_len <= LEN_W'(KW_CHARS)) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (prefix == KW_TEXT[i]) begin
                    kind = K_KW0 + KIND_W'(i);
                end
            end
        end
        return kind;
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
        logic [KIND_W-1:0] kind;
        kind = K_EOF;
        for (int i = 0; i < SINGLE_COUNT; i++) begin
            if (b == SINGLE_CHAR[i]) begin
                kind = SINGLE_KIND[i];
            end
        end
        return kind;
    endfunction

    function automatic t_op_hit op_lookup(input logic [7:0] b);
        t_op_hit r;
        r = '0;
        for (int i = OP_COUNT - 1; i >= 0; i--) begin
            if (b == OP_LEAD[i]) begin
                r.hit = 1'b1;
                r.idx = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/source_byte_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer_top
// Streaming source tokenizer: one byte or end mark in, tokens out.
// Throughput: one input transfer per cycle while the token queue has room for
//   two more entries; a byte that emits two tokens sends them in turn on the single output port.
// Path: an input register, then the output queue, whose head drives the output.
// Reset: synchronous, active low; scanner at line 1, column 1, input register and queue empty.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_top
    import sbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] source_byte
    input  logic        i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [5:0] token_kind, [21:6] start_line,
                                     // [37:22] start_column, [53:38] token_length
    output logic        o_m_tlast    // last_of_run
);

    logic             r_in_valid;
    logic             r_in_action;
    logic [7:0]       r_in_byte;
    logic             fire;
    logic [CNT_W-1:0] fifo_cnt;
    t_emit            emit;
    t_entry           ent0, ent1, head;

    assign fire       = r_in_valid && (fifo_cnt <= CNT_W'(FIFO_DEPTH - 2));
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_action <= i_s_tuser;
            r_in_byte   <= i_s_tdata;
        end
    end

    sbt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_action (r_in_action),
        .i_byte   (r_in_byte),
        .o_emit   (emit)
    );

    always_comb begin
        ent0.tok  = emit.tok0;
        ent0.last = (emit.count == 2'd1);
        ent1.tok  = emit.tok1;
        ent1.last = 1'b1;
    end

    sbt_out_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (fire ? emit.count : 2'd0),
        .i_ent0     (ent0),
        .i_ent1     (ent1),
        .i_pop      (i_m_tready),
        .o_cnt      (fifo_cnt),
        .o_valid    (o_m_tvalid),
        .o_ent      (head)
    );

    assign o_m_tdata = {2'b00, head.tok.length, head.tok.column, head.tok.line,
                        head.tok.kind};
    assign o_m_tlast = head.last;

`include "source_byte_tokenizer_top_assert.svh"

    `SBT_ASSERT(a_fifo_no_overflow, fifo_cnt <= CNT_W'(FIFO_DEPTH))
    `SBT_ASSERT_NEXT(a_end_gives_token, fire && r_in_action, o_m_tvalid)

endmodule

FILE: rtl/sbt_core.sv
// ----------------------------------------------------------------------------
// sbt_core
// Scanner state and per-byte token decision; up to two tokens per transfer.
// ----------------------------------------------------------------------------
module sbt_core
    import sbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_action,
    input  logic [7:0] i_byte,
    output t_emit      o_emit
);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    t_mode               r_mode, n_mode;
    logic [2:0]          r_pend, n_pend;
    logic [PREFIX_W-1:0] r_prefix, n_prefix;
    logic [LEN_W-1:0]    r_run, n_run;
    logic [POS_W-1:0]    r_tok_line, n_tok_line;
    logic [POS_W-1:0]    r_tok_col, n_tok_col;
    logic [POS_W-1:0]    r_cur_line, n_cur_line;
    logic [POS_W-1:0]    r_cur_col, n_cur_col;

    logic       f_vld, s_vld, used;
    t_token     f_tok, s_tok;
    logic [2:0] pi;
    t_op_hit    op_hit;
    logic [KIND_W-1:0] sk;

    assign pi     = (r_pend != 3'd7) ? r_pend : 3'd0;
    assign op_hit = op_lookup(i_byte);
    assign sk     = single_kind(i_byte);

    always_comb begin
        n_mode     = r_mode;
        n_pend     = r_pend;
        n_prefix   = r_prefix;
        n_run      = r_run;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        f_vld      = 1'b0;
        s_vld      = 1'b0;
        f_tok      = '0;
        s_tok      = '0;
        used       = 1'b1;
        f_tok.line   = 16'(r_tok_line);
        f_tok.column = 16'(r_tok_col);
        f_tok.length = 16'(1);

        if (i_action) begin
            case (r_mode)
                M_WORD: begin
                    f_vld        = 1'b1;
                    f_tok.kind   = word_kind(r_prefix, r_run);
                    f_tok.length = 16'(r_run);
                end
                M_NUMBER: begin
                    f_vld        = 1'b1;
                    f_tok.kind   = K_INT;
                    f_tok.length = 16'(r_run);
                end
                M_OPER: begin
                    f_vld      = 1'b1;
                    f_tok.kind = OP_SINGLE[pi];
                end
                M_SLASH: begin
                    f_vld      = 1'b1;
                    f_tok.kind = K_SLASH;
                end
                default: ;
            endcase
            s_vld        = 1'b1;
            s_tok.kind   = K_EOF;
            s_tok.line   = 16'(r_cur_line);
            s_tok.column = 16'(r_cur_col);
            s_tok.length = '0;
            n_mode       = M_IDLE;
            n_pend       = '0;
            n_prefix     = '0;
            n_run        = '0;
            n_tok_line   = POS_ONE;
            n_tok_col    = POS_ONE;
            n_cur_line   = POS_ONE;
            n_cur_col    = POS_ONE;
        end else begin
            case (r_mode)
                M_WORD, M_NUMBER: begin
                    if (is_digit(i_byte) || (r_mode == M_WORD && is_letter(i_byte))) begin
                        for (int j = 0; j < KW_CHARS; j++) begin
                            if (r_run == LEN_W'(j)) begin
                                n_prefix[8*j +: 8] = r_prefix[8*j +: 8] | i_byte;
                            end
                        end
                        if (r_run != LEN_MAX) begin
                            n_run = r_run + LEN_W'(1);
                        end
                    end else begin
                        f_vld        = 1'b1;
                        f_tok.kind   = (r_mode == M_WORD) ? word_kind(r_prefix, r_run) : K_INT;
                        f_tok.length = 16'(r_run);
                        n_mode       = M_IDLE;
                        used         = 1'b0;
                    end
                end
                M_OPER: begin
                    f_vld = 1'b1;
                    if (i_byte == OP_NEXT1[pi]) begin
                        f_tok.kind   = OP_KIND1[pi];
                        f_tok.length = 16'(2);
                    end else if (OP_NEXT2[pi] != 8'h00 && i_byte == OP_NEXT2[pi]) begin
                        f_tok.kind   = OP_KIND2[pi];
                        f_tok.length = 16'(2);
                    end else begin
                        f_tok.kind = OP_SINGLE[pi];
                        used       = 1'b0;
                    end
                    n_mode = M_IDLE;
                end
                M_SLASH: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_LINE;
                    end else if (i_byte == CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else begin
                        f_vld      = 1'b1;
                        f_tok.kind = K_SLASH;
                        n_mode     = M_IDLE;
                        used       = 1'b0;
                    end
                end
                M_LINE: begin
                    if (i_byte == CH_LF) begin
                        n_mode = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (i_byte == CH_STAR) begin
                        n_mode = M_BLOCK_STAR;
                    end
                end
                M_BLOCK_STAR: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else if (i_byte != CH_STAR) begin
                        n_mode = M_BLOCK;
                    end
                end
                M_HALT: ;
                default: begin
                    n_mode = M_IDLE;
                    used   = 1'b0;
                end
            endcase

            // start of a new token
            if (!used && !is_blank(i_byte)) begin
                n_tok_line   = r_cur_line;
                n_tok_col    = r_cur_col;
                s_tok.line   = 16'(r_cur_line);
                s_tok.column = 16'(r_cur_col);
                s_tok.length = 16'(1);
                if (is_letter(i_byte) || is_digit(i_byte)) begin
                    n_mode   = is_digit(i_byte) ? M_NUMBER : M_WORD;
                    n_run    = LEN_W'(1);
                    n_prefix = PREFIX_W'(i_byte);
                end else if (sk != K_EOF) begin
                    s_vld      = 1'b1;
                    s_tok.kind = sk;
                end else if (op_hit.hit) begin
                    n_mode = M_OPER;
                    n_pend = op_hit.idx;
                end else if (i_byte == CH_SLASH) begin
                    n_mode = M_SLASH;
                end else begin
                    n_mode     = M_HALT;
                    s_vld      = 1'b1;
                    s_tok.kind = K_BAD;
                end
            end

            if (i_byte == CH_LF) begin
                if (r_cur_line != POS_MAX) begin
                    n_cur_line = r_cur_line + POS_ONE;
                end
                n_cur_col = POS_ONE;
            end else if (r_cur_col != POS_MAX) begin
                n_cur_col = r_cur_col + POS_ONE;
            end
        end
    end

    always_comb begin
        o_emit.count = {1'b0, f_vld} + {1'b0, s_vld};
        o_emit.tok0  = f_vld ? f_tok : s_tok;
        o_emit.tok1  = s_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_pend     <= '0;
            r_prefix   <= '0;
            r_run      <= '0;
            r_tok_line <= POS_ONE;
            r_tok_col  <= POS_ONE;
            r_cur_line <= POS_ONE;
            r_cur_col  <= POS_ONE;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_pend     <= n_pend;
            r_prefix   <= n_prefix;
            r_run      <= n_run;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_cur_line <= n_cur_line;
            r_cur_col  <= n_cur_col;
        end
    end

endmodule

FILE: rtl/sbt_out_fifo.sv
// ----------------------------------------------------------------------------
// sbt_out_fifo
// Small token queue; takes up to two entries per cycle, gives one.
// ----------------------------------------------------------------------------
module sbt_out_fifo
    import sbt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  t_entry           i_ent0,
    input  t_entry           i_ent1,
    input  logic             i_pop,
    output logic [CNT_W-1:0] o_cnt,
    output logic             o_valid,
    output t_entry           o_ent
);

    t_entry             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_cnt   = r_cnt;
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_ent0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + FIFO_AW'(1)] <= i_ent1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + FIFO_AW'(i_push_cnt);
            r_rp  <= r_rp + FIFO_AW'(pop_ok);
            r_cnt <= r_cnt + CNT_W'(i_push_cnt) - CNT_W'(pop_ok);
        end
    end

endmodule

FILE: tb/source_byte_tokenizer_top_test.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer_top_test
// Self-checking bench for the streaming source tokenizer. A behavioral
// scanner predicts every token from the accepted bytes and end marks, and
// each output transfer is compared field by field with the oldest
// prediction. Directed cases cover lookahead, end-mark flushing, comments,
// unsupported characters, long identifiers and runs of empty lines. Random programs
// of keywords, identifiers, numbers, operators, blanks and comments follow,
// mixed with noise bytes, random stalls on both sides and drain pauses.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_top_test
    import sbt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          IDLE_PCT     = 11;
    localparam int          TAIL_CYCLES  = 16;
    localparam int          OP_TEXTS     = 30;
    localparam logic [15:0] POS_LIMIT    = 16'((64'd1 << POS_W) - 64'd1);
    localparam logic [15:0] LEN_LIMIT    = 16'hFFFF;
    localparam logic        ACT_BYTE     = 1'b0;
    localparam logic        ACT_END      = 1'b1;

    typedef enum logic [5:0] {
        TK_EOF, TK_IDENT, TK_INT,
        TK_FN, TK_LET, TK_MUT, TK_IF, TK_ELSE, TK_RETURN, TK_I32, TK_TRUE,
        TK_FALSE, TK_WHILE, TK_FOR, TK_LOOP, TK_MATCH, TK_UNSAFE,
        TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_LBRACK, TK_RBRACK,
        TK_COMMA, TK_SEMI, TK_COLON, TK_ARROW, TK_ASSIGN, TK_PLUS, TK_MINUS,
        TK_STAR, TK_SLASH, TK_PERCENT, TK_BANG, TK_LT, TK_LE, TK_GT, TK_GE,
        TK_EQ, TK_NE, TK_AMP, TK_ANDAND, TK_PIPE, TK_OROR, TK_CARET,
        TK_SHL, TK_SHR, TK_BAD
    } t_tok_kind;

    typedef struct {
        t_tok_kind   kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic        last;
    } t_due_token;

    string keywords [KW_COUNT] = '{"fn", "let", "mut", "if", "else", "return", "i32",
                                   "true", "false", "while", "for", "loop", "match",
                                   "unsafe"};
    string operators [OP_TEXTS] = '{"(", ")", "{", "}", "[", "]", ",", ";", ":", "->",
                                    "=", "+", "-", "*", "/", "%", "!", "<", "<=", ">",
                                    ">=", "==", "!=", "&", "&&", "|", "||", "^", "<<",
                                    ">>"};

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] source_byte
    logic        i_s_tuser  = 1'b0;    // [0] action
    logic        i_m_tready = 1'b0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [55:0] o_m_tdata;            // [5:0] kind, [21:6] line, [37:22] column,
                                       // [53:38] length
    wire         o_m_tlast;

    // scanner state of the predictor
    t_mode          scan_state;
    logic [7:0]     op_lead;
    logic [PREFIX_W-1:0] word_head;
    logic [15:0]    run_len;
    logic [15:0]    tok_line, tok_col, cur_line, cur_col;

    t_due_token     tokens_due [$];
    t_due_token     got_token;

    bit             steady = 1'b0;
    int             errors = 0;
    int             cycle_count = 0;
    int             tokens_checked = 0;
    int             items_sent = 0;
    int             ends_sent = 0;
    int             programs = 0;

    source_byte_tokenizer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------- scanner

    function automatic bit letter_char(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit digit_char(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit blank_char(logic [7:0] b);
        return b == " " || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic t_tok_kind lone_punct(logic [7:0] b);
        case (b)
            "(": return TK_LPAREN;
            ")": return TK_RPAREN;
            "{": return TK_LBRACE;
            "}": return TK_RBRACE;
            "[": return TK_LBRACK;
            "]": return TK_RBRACK;
            ",": return TK_COMMA;
            ";": return TK_SEMI;
            ":": return TK_COLON;
            "+": return TK_PLUS;
            "*": return TK_STAR;
            "%": return TK_PERCENT;
            "^": return TK_CARET;
            default: return TK_EOF;
        endcase
    endfunction

    function automatic bit op_start(logic [7:0] b);
        return b == "-" || b == "!" || b == "=" || b == "<" || b == ">" ||
               b == "&" || b == "|";
    endfunction

    function automatic t_tok_kind op_lone(logic [7:0] lead);
        case (lead)
            "-": return TK_MINUS;
            "!": return TK_BANG;
            "=": return TK_ASSIGN;
            "<": return TK_LT;
            ">": return TK_GT;
            "&": return TK_AMP;
            default: return TK_PIPE;
        endcase
    endfunction

    // TK_EOF when the byte does not complete a two-character operator
    function automatic t_tok_kind op_double(logic [7:0] lead, logic [7:0] b);
        case (lead)
            "-": return (b == ">") ? TK_ARROW : TK_EOF;
            "!": return (b == "=") ? TK_NE : TK_EOF;
            "=": return (b == "=") ? TK_EQ : TK_EOF;
            "<": return (b == "=") ? TK_LE : (b == "<") ? TK_SHL : TK_EOF;
            ">": return (b == "=") ? TK_GE : (b == ">") ? TK_SHR : TK_EOF;
            "&": return (b == "&") ? TK_ANDAND : TK_EOF;
            default: return (b == "|") ? TK_OROR : TK_EOF;
        endcase
    endfunction

    function automatic t_tok_kind word_class();
        logic [PREFIX_W-1:0] text;
        if (run_len > KW_CHARS) return TK_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            text = '0;
            for (int j = 0; j < keywords[k].len(); j++) text[8*j +: 8] = keywords[k][j];
            if (text == word_head) return t_tok_kind'(int'(TK_FN) + k);
        end
        return TK_IDENT;
    endfunction

    function automatic void note_token(t_tok_kind kind, logic [15:0] line,
                                       logic [15:0] column, logic [15:0] length);
        t_due_token t;
        t.kind   = kind;
        t.line   = line;
        t.column = column;
        t.length = length;
        t.last   = 1'b0;
        tokens_due.insert(tokens_due.size(), t);
    endfunction

    function automatic void reset_scanner();
        scan_state = M_IDLE;
        op_lead    = 8'h00;
        word_head  = '0;
        run_len    = '0;
        tok_line   = 16'd1;
        tok_col    = 16'd1;
        cur_line   = 16'd1;
        cur_col    = 16'd1;
    endfunction

    function automatic void grow_run(logic [7:0] b);
        if (run_len < KW_CHARS) word_head[8*run_len +: 8] = b;
        if (run_len != LEN_LIMIT) run_len++;
    endfunction

    function automatic void flush_run();
        case (scan_state)
            M_WORD:   note_token(word_class(), tok_line, tok_col, run_len);
            M_NUMBER: note_token(TK_INT, tok_line, tok_col, run_len);
            M_OPER:   note_token(op_lone(op_lead), tok_line, tok_col, 16'd1);
            M_SLASH:  note_token(TK_SLASH, tok_line, tok_col, 16'd1);
            default: ;
        endcase
        scan_state = M_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] b);
        t_tok_kind p;
        if (blank_char(b)) return;
        tok_line = cur_line;
        tok_col  = cur_col;
        p = lone_punct(b);
        if (letter_char(b) || digit_char(b)) begin
            scan_state = digit_char(b) ? M_NUMBER : M_WORD;
            run_len    = '0;
            word_head  = '0;
            grow_run(b);
        end else if (p != TK_EOF) begin
            note_token(p, tok_line, tok_col, 16'd1);
        end else if (op_start(b)) begin
            scan_state = M_OPER;
            op_lead    = b;
        end else if (b == CH_SLASH) begin
            scan_state = M_SLASH;
        end else begin
            scan_state = M_HALT;
            note_token(TK_BAD, tok_line, tok_col, 16'd1);
        end
    endfunction

    function automatic void scan_item(logic action, logic [7:0] b);
        int        first;
        bit        restart;
        t_tok_kind pair;
        first   = tokens_due.size();
        restart = 1'b0;
        if (action == ACT_END) begin
            flush_run();
            note_token(TK_EOF, cur_line, cur_col, 16'd0);
            reset_scanner();
        end else begin
            case (scan_state)
                M_WORD, M_NUMBER: begin
                    if (digit_char(b) || (scan_state == M_WORD && letter_char(b))) begin
                        grow_run(b);
                    end else begin
                        flush_run();
                        restart = 1'b1;
                    end
                end
                M_OPER: begin
                    pair = op_double(op_lead, b);
                    if (pair != TK_EOF) begin
                        note_token(pair, tok_line, tok_col, 16'd2);
                    end else begin
                        note_token(op_lone(op_lead), tok_line, tok_col, 16'd1);
                        restart = 1'b1;
                    end
                    scan_state = M_IDLE;
                end
                M_SLASH: begin
                    if (b == CH_SLASH) begin
                        scan_state = M_LINE;
                    end else if (b == CH_STAR) begin
                        scan_state = M_BLOCK;
                    end else begin
                        flush_run();
                        restart = 1'b1;
                    end
                end
                M_LINE: begin
                    if (b == CH_LF) scan_state = M_IDLE;
                end
                M_BLOCK: begin
                    if (b == CH_STAR) scan_state = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (b == CH_SLASH) scan_state = M_IDLE;
                    else if (b != CH_STAR) scan_state = M_BLOCK;
                end
                M_HALT: ;
                default: begin
                    scan_state = M_IDLE;
                    restart    = 1'b1;
                end
            endcase
            if (restart) start_token(b);
            if (b == CH_LF) begin
                if (cur_line != POS_LIMIT) cur_line++;
                cur_col = 16'd1;
            end else if (cur_col != POS_LIMIT) begin
                cur_col++;
            end
        end
        if (tokens_due.size() > first) tokens_due[tokens_due.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checker

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (tokens_due.size() == 0) begin
                $error("token transfer with nothing due: kind %0d line %0d column %0d",
                       o_m_tdata[5:0], o_m_tdata[21:6], o_m_tdata[37:22]);
                errors++;
            end else begin
                got_token = tokens_due.pop_front();
                check_field("token_kind", got_token.kind, o_m_tdata[5:0]);
                check_field("start_line", got_token.line, o_m_tdata[21:6]);
                check_field("start_column", got_token.column, o_m_tdata[37:22]);
                check_field("token_length", got_token.length, o_m_tdata[53:38]);
                check_field("tdata_pad", 0, o_m_tdata[55:54]);
                check_field("last_of_run", got_token.last, o_m_tlast);
            end
            tokens_checked++;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_item(logic action, logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= action;
        do @(posedge i_clk); while (!o_s_tready);
        scan_item(action, b);
        items_sent++;
        if (action == ACT_END) ends_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i]);
    endtask

    task automatic send_end();
        send_item(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] ident_char(bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r < 5) ? 8'(9 + r) : " ";
    endfunction

    task automatic send_fragment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_text(keywords[$urandom_range(0, KW_COUNT - 1)]);
        end else if (pick < 30) begin
            send_item(ACT_BYTE, ident_char(1'b1));
            repeat ($urandom_range(0, 9)) send_item(ACT_BYTE, ident_char(1'b0));
        end else if (pick < 42) begin
            repeat ($urandom_range(1, 6)) send_item(ACT_BYTE, 8'("0" + $urandom_range(0, 9)));
        end else if (pick < 66) begin
            send_text(operators[$urandom_range(0, OP_TEXTS - 1)]);
        end else if (pick < 82) begin
            send_item(ACT_BYTE, blank_byte());
        end else if (pick < 88) begin
            send_text("//");
            repeat ($urandom_range(0, 8)) send_item(ACT_BYTE, 8'($urandom_range(32, 126)));
            send_item(ACT_BYTE, CH_LF);
        end else if (pick < 95) begin
            send_text("/*");
            repeat ($urandom_range(0, 8)) begin
                if ($urandom_range(0, 2) == 0) send_item(ACT_BYTE, CH_STAR);
                else send_item(ACT_BYTE, 8'($urandom_range(10, 126)));
            end
            if ($urandom_range(0, 1)) send_item(ACT_BYTE, CH_STAR);
            send_text("*/");
        end else if (pick < 97) begin
            send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
        end else begin
            // comment left open: swallows text until a later close or the end mark
            send_text("/*");
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_tokens();
        // keyword, over-long word with keyword prefix, lookahead splits
        send_text("unsafe returns_ 7<<=z!=/");
        send_end();
    endtask

    task automatic test_end_flush();
        send_text("ab");
        send_end();
        send_text("90");
        send_end();
        send_text(">");
        send_end();
        send_text("//x");
        send_end();
        send_text("/*o");
        send_end();
        send_end();
    endtask

    task automatic test_bad_char();
        send_text("a");
        send_item(ACT_BYTE, 8'h00);
        send_text("b\n");
        send_item(ACT_BYTE, 8'hFF);
        send_end();
        send_item(ACT_BYTE, 8'h80);
        send_end();
    endtask

    task automatic test_long_runs();
        // long identifier, then a run of empty lines
        send_item(ACT_BYTE, "w");
        repeat (120) send_item(ACT_BYTE, ident_char(1'b0));
        send_text("+");
        repeat (40) send_item(ACT_BYTE, CH_LF);
        send_text("q");
        send_end();
    endtask

    task automatic test_random_programs();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            steady = (programs >= 8 && programs < 20);
            repeat ($urandom_range(3, 30)) begin
                send_fragment();
                if ($urandom_range(0, 99) < 40) send_item(ACT_BYTE, blank_byte());
            end
            // hold a token pending while the output drains
            if ($urandom_range(0, 5) == 0) wait_drain();
            send_end();
            programs++;
        end
        steady = 1'b0;
    endtask

    initial begin
        reset_scanner();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_tokens();
        test_end_flush();
        test_bad_char();
        test_long_runs();
        test_random_programs();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run: %0d transfers in (%0d end marks), %0d random programs, %0d tokens",
                 items_sent, ends_sent, programs, tokens_checked);
        $display("covered lookahead, flushing, comments, bad bytes and long runs; %0d errors",
                 errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
